/* design/bwc_pkg.sv */
// Package for the byte wheel cipher core: sizes, function codes, register
// indexes and the result and queue status types.
// No dependencies.
`timescale 1ns / 1ps

package bwc_pkg;

  localparam int unsigned MAX_DISKS    = 32;
  localparam int unsigned SYMBOLS      = 256;
  localparam int unsigned DISK_W       = $clog2(MAX_DISKS);
  localparam int unsigned SYM_W        = $clog2(SYMBOLS);
  localparam int unsigned TBL_ADDR_W   = DISK_W + SYM_W;
  localparam int unsigned PTR_W        = $clog2(MAX_DISKS + 1);
  localparam int unsigned COUNT_W      = 6;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [COUNT_W-1:0] RST_DISK_COUNT = COUNT_W'(26);
  localparam logic [SYM_W-1:0]   RST_SHIFT      = SYM_W'(1);

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_ENC     = 2'd1,
    FUNC_DEC     = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISK_COUNT = 1'd0,
    REG_SHIFT      = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [SYM_W-1:0]  out_byte;
    logic [DISK_W-1:0] disk_used;
  } res_t;

  typedef struct packed {
    logic                  valid;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

/* design/bwc_table_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
`timescale 1ns / 1ps

module bwc_table_ram #(
  parameter int unsigned ADDR_W = 13,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/bwc_out_fifo.sv */
// Small result queue between the table pipeline and the output channel.
// Depends on bwc_pkg for depth and result type.
`timescale 1ns / 1ps

module bwc_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bwc_pkg::res_t      push_data,
  input  logic               pop,
  output bwc_pkg::res_t      head,
  output bwc_pkg::fifo_stat_t stat
);

  bwc_pkg::res_t                   slots [bwc_pkg::FIFO_DEPTH];
  logic [bwc_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [bwc_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [bwc_pkg::FIFO_CNT_W-1:0]  count;
  logic                            do_pop;

  assign do_pop     = pop && (count != '0);
  assign head       = slots[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !do_pop && (count == bwc_pkg::FIFO_CNT_W'(bwc_pkg::FIFO_DEPTH))))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bwc_pkg::FIFO_CNT_W'(bwc_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

/* design/byte_wheel_cipher_core.sv */
// Top level of the byte wheel cipher: disk pointer, inverse and forward
// table memories, table read pipeline and result queue.
// Depends on bwc_pkg, bwc_table_ram and bwc_out_fifo.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | into core | in_valid / in_stall  | func, disk_index, entry_position, data_byte
//   out     | from core | out_valid / out_stall| out_byte, disk_used
//   cfg     | into core | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while in_stall is low. An accepted request reads the
// inverse table, then the forward table, and is then written into the result queue,
// which raises out_valid.
// in_stall comes from registers only: it rises when four requests are in
// flight or queued. The tables have no reset and need no clearing pass.
// Synchronous reset clears the pointer and pipeline valids and loads the config defaults.
`timescale 1ns / 1ps

module byte_wheel_cipher_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [bwc_pkg::DISK_W-1:0]      disk_index,
  input  logic [bwc_pkg::SYM_W-1:0]       entry_position,
  input  logic [bwc_pkg::SYM_W-1:0]       data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bwc_pkg::SYM_W-1:0]       out_byte,
  output logic [bwc_pkg::DISK_W-1:0]      disk_used,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bwc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [bwc_pkg::COUNT_W-1:0] disk_count;
  logic [bwc_pkg::SYM_W-1:0]   shift_amount;

  // pointer and front end
  logic [bwc_pkg::PTR_W-1:0]   disk_pointer;
  logic [bwc_pkg::PTR_W-1:0]   live_cnt;
  logic [bwc_pkg::PTR_W-1:0]   cur_disk;
  bwc_pkg::func_t              func0;
  logic                        accept;
  logic                        crypt0;

  // stage 1: inverse data back
  logic                        v1;
  bwc_pkg::func_t              f1;
  logic [bwc_pkg::DISK_W-1:0]  d1;
  logic [bwc_pkg::SYM_W-1:0]   inv_pos;
  logic [bwc_pkg::SYM_W-1:0]   rot_pos;

  // stage 2: forward data back
  logic                        v2;
  bwc_pkg::func_t              f2;
  logic [bwc_pkg::DISK_W-1:0]  d2;
  logic [bwc_pkg::SYM_W-1:0]   fwd_byte;

  bwc_pkg::res_t               res2;
  bwc_pkg::res_t               head;
  bwc_pkg::fifo_stat_t         qstat;
  logic [bwc_pkg::FIFO_CNT_W:0] in_flight;

  assign func0  = bwc_pkg::func_t'(func);
  assign accept = in_valid && !in_stall;
  assign crypt0 = (func0 == bwc_pkg::FUNC_ENC) || (func0 == bwc_pkg::FUNC_DEC);

  assign in_flight = {1'b0, qstat.count} + (bwc_pkg::FIFO_CNT_W + 1)'(v1)
                   + (bwc_pkg::FIFO_CNT_W + 1)'(v2);
  assign in_stall  = in_flight >= (bwc_pkg::FIFO_CNT_W + 1)'(bwc_pkg::FIFO_DEPTH);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_count   <= bwc_pkg::RST_DISK_COUNT;
      shift_amount <= bwc_pkg::RST_SHIFT;
    end else if (cfg_valid && cfg_ready) begin
      case (bwc_pkg::cfg_reg_t'(cfg_index))
        bwc_pkg::REG_DISK_COUNT: disk_count   <= cfg_data[bwc_pkg::COUNT_W-1:0];
        bwc_pkg::REG_SHIFT:      shift_amount <= cfg_data[bwc_pkg::SYM_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, anything past the table size saturates
  always_comb begin
    if (disk_count == '0) begin
      live_cnt = bwc_pkg::PTR_W'(1);
    end else if (disk_count > bwc_pkg::COUNT_W'(bwc_pkg::MAX_DISKS)) begin
      live_cnt = bwc_pkg::PTR_W'(bwc_pkg::MAX_DISKS);
    end else begin
      live_cnt = bwc_pkg::PTR_W'(disk_count);
    end
  end

  assign cur_disk = (disk_pointer >= live_cnt) ? '0 : disk_pointer;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_pointer <= '0;
    end else if (accept) begin
      if (func0 == bwc_pkg::FUNC_RESTART) begin
        disk_pointer <= '0;
      end else if (crypt0) begin
        disk_pointer <= cur_disk + 1'b1;
      end
    end
  end

  // Both tables are written at acceptance; the inverse is read at acceptance, the forward later.
  // A forward read that meets a younger load on the same edge gets the
  // old entry, which is the right order, so no forwarding is needed.
  bwc_table_ram #(
    .ADDR_W(bwc_pkg::TBL_ADDR_W),
    .DATA_W(bwc_pkg::SYM_W)
  ) u_inverse (
    .clk   (clk),
    .we    (accept && (func0 == bwc_pkg::FUNC_LOAD)),
    .waddr ({disk_index, data_byte}),
    .wdata (entry_position),
    .re    (accept && crypt0),
    .raddr ({cur_disk[bwc_pkg::DISK_W-1:0], data_byte}),
    .rdata (inv_pos)
  );

  assign rot_pos = (f1 == bwc_pkg::FUNC_ENC) ? (inv_pos + shift_amount)
                                             : (inv_pos - shift_amount);

  bwc_table_ram #(
    .ADDR_W(bwc_pkg::TBL_ADDR_W),
    .DATA_W(bwc_pkg::SYM_W)
  ) u_forward (
    .clk   (clk),
    .we    (accept && (func0 == bwc_pkg::FUNC_LOAD)),
    .waddr ({disk_index, entry_position}),
    .wdata (data_byte),
    .re    (v1),
    .raddr ({d1, rot_pos}),
    .rdata (fwd_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    f1 <= func0;
    d1 <= cur_disk[bwc_pkg::DISK_W-1:0];
    f2 <= f1;
    d2 <= d1;
  end

  always_comb begin
    if ((f2 == bwc_pkg::FUNC_ENC) || (f2 == bwc_pkg::FUNC_DEC)) begin
      res2.out_byte  = fwd_byte;
      res2.disk_used = d2;
    end else begin
      res2.out_byte  = '0;
      res2.disk_used = '0;
    end
  end

  bwc_out_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (v2),
    .push_data (res2),
    .pop       (out_valid && !out_stall),
    .head      (head),
    .stat      (qstat)
  );

  assign out_valid = qstat.valid;
  assign out_byte  = head.out_byte;
  assign disk_used = head.disk_used;

  a_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_flight <= (bwc_pkg::FIFO_CNT_W + 1)'(bwc_pkg::FIFO_DEPTH))
    else $error("more requests in flight than queue slots");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    disk_pointer <= bwc_pkg::PTR_W'(bwc_pkg::MAX_DISKS))
    else $error("disk pointer past table size");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && (func0 == bwc_pkg::FUNC_RESTART)) |=> (disk_pointer == '0))
    else $error("restart did not clear disk pointer");

  a_disk_live: assert property (@(posedge clk) disable iff (rst)
    (accept && crypt0) |-> (cur_disk < live_cnt))
    else $error("disk chosen outside live count");

endmodule

/* test/tb_byte_wheel_cipher_core.sv */
// Self-checking testbench for byte_wheel_cipher_core: directed table, disk fill
// and random request phases under varied idling, checked against a local predictor.
// Depends on bwc_pkg and byte_wheel_cipher_core.
`timescale 1ns / 1ps

module tb_byte_wheel_cipher_core;

  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 70;
  localparam int unsigned FILL_DISKS   = 4;
  localparam int unsigned TABLE_DEPTH  = bwc_pkg::MAX_DISKS * bwc_pkg::SYMBOLS;

  typedef struct packed {
    bwc_pkg::func_t             func;
    logic [bwc_pkg::DISK_W-1:0] disk;
    logic [bwc_pkg::SYM_W-1:0]  pos;
    logic [bwc_pkg::SYM_W-1:0]  data;
  } cipher_req_t;

  typedef struct {
    cipher_req_t   req;
    bit            typed;
    bwc_pkg::res_t res;
  } table_row_t;

  logic                           clk            = 1'b0;
  logic                           rst            = 1'b1;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic [1:0]                     func           = bwc_pkg::FUNC_LOAD;
  logic [bwc_pkg::DISK_W-1:0]     disk_index     = '0;
  logic [bwc_pkg::SYM_W-1:0]      entry_position = '0;
  logic [bwc_pkg::SYM_W-1:0]      data_byte      = '0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic [bwc_pkg::SYM_W-1:0]      out_byte;
  logic [bwc_pkg::DISK_W-1:0]     disk_used;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [bwc_pkg::CFG_IDX_W-1:0]  cfg_index      = bwc_pkg::REG_DISK_COUNT;
  logic [bwc_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

  // predictor copy of the block state and registers
  logic [bwc_pkg::SYM_W-1:0]   fwd_disk [TABLE_DEPTH];
  logic [bwc_pkg::SYM_W-1:0]   inv_disk [TABLE_DEPTH];
  bit                          fwd_set  [TABLE_DEPTH];
  bit                          inv_set  [TABLE_DEPTH];
  logic [bwc_pkg::COUNT_W-1:0] wheel_ptr    = '0;
  logic [bwc_pkg::COUNT_W-1:0] disk_count_q = bwc_pkg::RST_DISK_COUNT;
  logic [bwc_pkg::SYM_W-1:0]   shift_q      = bwc_pkg::RST_SHIFT;

  bwc_pkg::res_t due_results [$];
  int unsigned   mismatches     = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   quiet_cycles   = 0;

  // shift 1, 26 disks, pointer at 0 after reset
  table_row_t directed_rows [17] = '{
    '{'{bwc_pkg::FUNC_LOAD,    5'd0,  8'h00, 8'h00}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_LOAD,    5'd0,  8'h01, 8'hFF}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_LOAD,    5'd0,  8'hFF, 8'h80}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_LOAD,    5'd31, 8'hFF, 8'hFF}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_LOAD,    5'd31, 8'h00, 8'h00}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_ENC,     5'd31, 8'hAA, 8'h00}, 1'b1, '{8'hFF, 5'd0}},
    '{'{bwc_pkg::FUNC_RESTART, 5'd31, 8'hFF, 8'hFF}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_DEC,     5'd17, 8'h55, 8'h00}, 1'b1, '{8'h80, 5'd0}},
    '{'{bwc_pkg::FUNC_RESTART, 5'd0,  8'h00, 8'h00}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_ENC,     5'd0,  8'h00, 8'h80}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_RESTART, 5'd0,  8'h00, 8'h00}, 1'b1, '{8'h00, 5'd0}},
    // same value loaded twice: the later position wins in the inverse
    '{'{bwc_pkg::FUNC_LOAD,    5'd0,  8'h02, 8'h00}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_LOAD,    5'd0,  8'h03, 8'h55}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_ENC,     5'd0,  8'h00, 8'h00}, 1'b0, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_RESTART, 5'd0,  8'h00, 8'h00}, 1'b1, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_DEC,     5'd0,  8'h00, 8'hFF}, 1'b0, '{8'h00, 5'd0}},
    '{'{bwc_pkg::FUNC_RESTART, 5'd0,  8'h00, 8'h00}, 1'b1, '{8'h00, 5'd0}}
  };

  logic [7:0] count_plan [PHASES] = '{8'd26, 8'hC0, 8'd3, 8'hFF, 8'd1, 8'hC4, 8'd0, 8'd4};
  logic [7:0] shift_plan [PHASES] = '{8'd1, 8'd0, 8'd255, 8'd128, 8'h3C, 8'h7F, 8'd0, 8'd1};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_wheel_cipher_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .disk_index     (disk_index),
    .entry_position (entry_position),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .disk_used      (disk_used),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // zero counts as one, past the table size saturates
  function automatic logic [bwc_pkg::COUNT_W-1:0] live_disks();
    logic [bwc_pkg::COUNT_W-1:0] live;
    live = disk_count_q;
    if (live == 0) live = bwc_pkg::COUNT_W'(1);
    if (live > bwc_pkg::MAX_DISKS) live = bwc_pkg::COUNT_W'(bwc_pkg::MAX_DISKS);
    return live;
  endfunction

  // True when a crypt request sent now would only read loaded entries.
  function automatic bit crypt_loaded(input cipher_req_t r);
    logic [bwc_pkg::COUNT_W-1:0] live;
    logic [bwc_pkg::COUNT_W-1:0] ptr;
    logic [bwc_pkg::DISK_W-1:0]  d;
    logic [bwc_pkg::SYM_W-1:0]   p;
    logic [bwc_pkg::SYM_W-1:0]   q;
    live = live_disks();
    ptr  = (wheel_ptr >= live) ? '0 : wheel_ptr;
    d    = ptr[bwc_pkg::DISK_W-1:0];
    if (!inv_set[{d, r.data}]) return 1'b0;
    p = inv_disk[{d, r.data}];
    q = (r.func == bwc_pkg::FUNC_ENC) ? p + shift_q : p - shift_q;
    return fwd_set[{d, q}];
  endfunction

  // Advances the predicted state by one request and returns the result it gives.
  function automatic bwc_pkg::res_t wheel_step(input cipher_req_t r);
    bwc_pkg::res_t               o;
    logic [bwc_pkg::COUNT_W-1:0] live;
    logic [bwc_pkg::DISK_W-1:0]  d;
    logic [bwc_pkg::SYM_W-1:0]   p;
    logic [bwc_pkg::SYM_W-1:0]   q;
    o = '0;
    case (r.func)
      bwc_pkg::FUNC_LOAD: begin
        fwd_disk[{r.disk, r.pos}]  = r.data;
        inv_disk[{r.disk, r.data}] = r.pos;
        fwd_set[{r.disk, r.pos}]   = 1'b1;
        inv_set[{r.disk, r.data}]  = 1'b1;
      end
      bwc_pkg::FUNC_RESTART: begin
        wheel_ptr = '0;
      end
      default: begin
        live = live_disks();
        // also covers a pointer left above a freshly lowered count
        if (wheel_ptr >= live) wheel_ptr = '0;
        d = wheel_ptr[bwc_pkg::DISK_W-1:0];
        p = inv_disk[{d, r.data}];
        q = (r.func == bwc_pkg::FUNC_ENC) ? p + shift_q : p - shift_q;
        o.out_byte  = fwd_disk[{d, q}];
        o.disk_used = d;
        wheel_ptr   = wheel_ptr + 1'b1;
      end
    endcase
    return o;
  endfunction

  task automatic send_req(input cipher_req_t r, input bit typed,
                          input bwc_pkg::res_t typed_res);
    bwc_pkg::res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= r.func;
    disk_index     <= r.disk;
    entry_position <= r.pos;
    data_byte      <= r.data;
    do @(posedge clk); while (in_stall);
    predicted = wheel_step(r);
    due_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic write_config(input logic [7:0] count_val, input logic [7:0] shift_val);
    cfg_valid <= 1'b1;
    cfg_index <= bwc_pkg::REG_DISK_COUNT;
    cfg_data  <= count_val;
    do @(posedge clk); while (!cfg_ready);
    disk_count_q = count_val[bwc_pkg::COUNT_W-1:0];
    cfg_index <= bwc_pkg::REG_SHIFT;
    cfg_data  <= shift_val;
    do @(posedge clk); while (!cfg_ready);
    shift_q = shift_val;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: check accepted results, then pick next cycle's stall
  always @(posedge clk) begin
    bwc_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: out_byte %0h disk_used %0d", out_byte, disk_used);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
          mismatches++;
        end
        if (disk_used !== want.disk_used) begin
          $error("disk_used: expected %0d, got %0d", want.disk_used, disk_used);
          mismatches++;
        end
      end
    end
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    cipher_req_t r;
    logic [7:0]  perm [bwc_pkg::SYMBOLS];
    logic [7:0]  tmp;
    int unsigned j;
    int unsigned roll;
    logic [7:0]  count_val;
    logic [7:0]  shift_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    // shuffled permutation on the first disks; a crypt request that would
    // still touch an unloaded entry is sent as a restart instead
    for (int d = 0; d < FILL_DISKS; d++) begin
      for (int k = 0; k < bwc_pkg::SYMBOLS; k++) perm[k] = k[7:0];
      for (int k = bwc_pkg::SYMBOLS - 1; k > 0; k--) begin
        j       = $urandom_range(k, 0);
        tmp     = perm[k];
        perm[k] = perm[j];
        perm[j] = tmp;
      end
      for (int k = 0; k < bwc_pkg::SYMBOLS; k++) begin
        r = '{func: bwc_pkg::FUNC_LOAD, disk: d[bwc_pkg::DISK_W-1:0],
              pos: k[bwc_pkg::SYM_W-1:0], data: perm[k]};
        send_req(r, 1'b0, '0);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        drain_results();
        count_val = count_plan[ph];
        shift_val = shift_plan[ph];
        if (ph == 6) begin
          count_val = 8'($urandom_range(255));
          shift_val = 8'($urandom_range(255));
        end
        write_config(count_val, shift_val);
      end
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        r.func = (roll < 20) ? bwc_pkg::FUNC_LOAD : (roll < 55) ? bwc_pkg::FUNC_ENC :
                 (roll < 90) ? bwc_pkg::FUNC_DEC : bwc_pkg::FUNC_RESTART;
        r.disk = bwc_pkg::DISK_W'($urandom_range(bwc_pkg::MAX_DISKS - 1));
        r.pos  = bwc_pkg::SYM_W'($urandom_range(bwc_pkg::SYMBOLS - 1));
        r.data = bwc_pkg::SYM_W'($urandom_range(bwc_pkg::SYMBOLS - 1));
        if (((r.func == bwc_pkg::FUNC_ENC) || (r.func == bwc_pkg::FUNC_DEC)) &&
            !crypt_loaded(r))
          r.func = bwc_pkg::FUNC_RESTART;
        send_req(r, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* byte_wheel_cipher_core.f */
design/bwc_pkg.sv
design/bwc_table_ram.sv
design/bwc_out_fifo.sv
design/byte_wheel_cipher_core.sv
test/tb_byte_wheel_cipher_core.sv
